/* src/mcht_pkg.sv */
// mcht_pkg: shared types, constants and command/status codes for the hull block
// no dependencies
package mcht_pkg;

  localparam int DEF_HULL_DEPTH = 64;

  typedef enum logic [1:0] {
    CMD_ADD_BACK  = 2'd0,
    CMD_ADD_FRONT = 2'd1,
    CMD_QRY_INC   = 2'd2,
    CMD_QRY_DEC   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_ORDER    = 2'd3
  } status_t;

  // classified item handed from front to back
  typedef struct packed {
    cmd_t               cmd;
    logic signed [32:0] a;
    logic signed [62:0] b;
    logic signed [31:0] x;
    logic               neg;
  } item_t;

  typedef struct packed {
    logic signed [63:0] value;
    status_t            status;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_RD,
    S_CHK,
    S_POP_RD,
    S_POP_MUL,
    S_POP_LO,
    S_POP_HI,
    S_POP_CMP,
    S_WRITE,
    S_Q_RD,
    S_Q_MUL,
    S_Q_CMP,
    S_DONE
  } state_t;

endpackage

/* src/mcht_ram.sv */
// mcht_ram: generic single-write, single-read memory with registered read
// no dependencies
module mcht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/mcht_front.sv */
// mcht_front: input acceptance, mode resolution and a two-entry queue
// depends on mcht_pkg
module mcht_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [1:0]            in_cmd,
  input  logic [31:0]           in_slope,
  input  logic [61:0]           in_intercept,
  input  logic [31:0]           in_query_x,
  input  logic                  minimize,
  output logic                  q_valid,
  input  logic                  q_ready,
  output mcht_pkg::item_t       q_item
);
  import mcht_pkg::*;

  item_t ent_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  item_t cls;
  logic push, pop;

  // minimize mode negates the line and swaps the add end
  always_comb begin
    cls.neg = minimize;
    cls.x   = $signed(in_query_x);
    cls.a   = minimize ? -$signed({in_slope[31], in_slope})
                       : $signed({in_slope[31], in_slope});
    cls.b   = minimize ? -$signed({in_intercept[61], in_intercept})
                       : $signed({in_intercept[61], in_intercept});
    cls.cmd = cmd_t'(in_cmd);
    if (minimize && in_cmd == CMD_ADD_BACK) begin
      cls.cmd = CMD_ADD_FRONT;
    end else if (minimize && in_cmd == CMD_ADD_FRONT) begin
      cls.cmd = CMD_ADD_BACK;
    end
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_item    = ent_r[0];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // a push with a pop only happens with one entry held, so it lands in slot 0
  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r[0] <= push ? cls : ent_r[1];
    end else if (push) begin
      if (cnt_r == 2'd0) ent_r[0] <= cls;
      else ent_r[1] <= cls;
    end
  end
endmodule

/* src/mcht_back.sv */
// mcht_back: hull sequencer with line memories, cross-product pops and queries
// depends on mcht_pkg, mcht_ram
module mcht_back #(
  parameter int HULL_DEPTH = mcht_pkg::DEF_HULL_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  mcht_pkg::item_t   q_item,
  output logic              res_valid,
  input  logic              res_ready,
  output mcht_pkg::result_t res
);
  import mcht_pkg::*;

  localparam int AW = $clog2(HULL_DEPTH);
  localparam int CW = $clog2(HULL_DEPTH + 1);

  state_t st_r, st_nxt;
  item_t  it_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] t_r, t_nxt;       // back: remaining count; front: drop count
  logic signed [31:0] linc_r, linc_nxt, ldec_r, ldec_nxt;
  result_t res_r, res_nxt;
  logic    rv_r, rv_nxt;
  logic    ph_r, ph_nxt;           // which of two reads is in flight
  logic signed [32:0] a1_r, a1_nxt;
  logic signed [62:0] b1_r, b1_nxt;
  logic signed [127:0] p1_r, p2_r;
  logic signed [63:0] e0_r;
  logic signed [33:0] d1_r, d3_r;
  logic signed [63:0] d2_r, d4_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [32:0]   rd_a;
  logic [62:0]   rd_b;

  mcht_ram #(.WIDTH(33), .DEPTH(HULL_DEPTH)) u_slopes (
    .clk(clk), .we(we), .waddr(waddr), .wdata(it_r.a), .raddr(raddr), .rdata(rd_a));
  mcht_ram #(.WIDTH(63), .DEPTH(HULL_DEPTH)) u_icpts (
    .clk(clk), .we(we), .waddr(waddr), .wdata(it_r.b), .raddr(raddr), .rdata(rd_b));

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] p);
    logic [CW:0] s;
    begin
      s = {1'b0, p} + {{(CW+1-AW){1'b0}}, h};
      if (s >= (CW+1)'(HULL_DEPTH)) s = s - (CW+1)'(HULL_DEPTH);
      return s[AW-1:0];
    end
  endfunction

  logic is_add, is_back;
  assign is_add  = (it_r.cmd == CMD_ADD_BACK) || (it_r.cmd == CMD_ADD_FRONT);
  assign is_back = (it_r.cmd == CMD_ADD_BACK);

  // cross-product differences are registered after the second read; each
  // 34 x 64 product is then built from two 34 x 32 halves, low half then high half
  logic signed [63:0] d1, d2, d3, d4;
  logic signed [66:0] lo1, lo2;
  logic signed [65:0] hi1, hi2;
  logic signed [65:0] ev;
  always_comb begin
    // back: lines (a1,b1),(rd),(new);  front: (new),(a1,b1),(rd)
    if (is_back) begin
      d1 = 64'(it_r.a) - 64'(a1_r);
      d2 = 64'(b1_r) - 64'($signed(rd_b));
      d3 = 64'($signed(rd_a)) - 64'(a1_r);
      d4 = 64'(b1_r) - 64'(it_r.b);
    end else begin
      d1 = 64'($signed(rd_a)) - 64'(it_r.a);
      d2 = 64'(it_r.b) - 64'(b1_r);
      d3 = 64'(a1_r) - 64'(it_r.a);
      d4 = 64'(it_r.b) - 64'($signed(rd_b));
    end
    lo1 = d1_r * $signed({1'b0, d2_r[31:0]});
    lo2 = d3_r * $signed({1'b0, d4_r[31:0]});
    hi1 = d1_r * $signed(d2_r[63:32]);
    hi2 = d3_r * $signed(d4_r[63:32]);
    ev = 66'($signed(rd_a)) * 66'(it_r.x) + 66'($signed(rd_b));
  end

  logic [CW-1:0] live;
  assign live = is_back ? t_r : cnt_r - t_r;

  always_comb begin
    st_nxt = st_r; head_nxt = head_r; cnt_nxt = cnt_r; t_nxt = t_r;
    linc_nxt = linc_r; ldec_nxt = ldec_r; res_nxt = res_r; rv_nxt = rv_r;
    ph_nxt = ph_r; a1_nxt = a1_r; b1_nxt = b1_r;
    q_ready = 1'b0; we = 1'b0; waddr = head_r; raddr = head_r;
    if (rv_r && res_ready) rv_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        q_ready = !rv_r;
        if (q_valid && !rv_r) st_nxt = S_CHK_RD;
      end
      S_CHK_RD: begin
        res_nxt = '{value: '0, status: ST_OK};
        ph_nxt = 1'b0;
        if (is_add) begin
          t_nxt = is_back ? cnt_r : '0;
          raddr = is_back ? slot(head_r, cnt_r - 1'b1) : head_r;
          st_nxt = (cnt_r == '0) ? S_WRITE : S_CHK;
          if (cnt_r == '0 && cnt_r >= CW'(HULL_DEPTH)) st_nxt = S_DONE;
        end else if (it_r.cmd == CMD_QRY_INC ? (it_r.x < linc_r) : (it_r.x > ldec_r)) begin
          res_nxt.status = ST_ORDER; st_nxt = S_DONE;
        end else if (cnt_r == '0) begin
          res_nxt.status = ST_EMPTY; st_nxt = S_DONE;
        end else begin
          if (it_r.cmd == CMD_QRY_INC) linc_nxt = it_r.x; else ldec_nxt = it_r.x;
          st_nxt = S_Q_RD;
        end
      end
      S_CHK: begin
        // rd holds the end line
        if (is_back ? ($signed(rd_a) > it_r.a) : (it_r.a > $signed(rd_a))) begin
          res_nxt.status = ST_ORDER; st_nxt = S_DONE;
        end else st_nxt = S_POP_RD;
      end
      S_POP_RD: begin
        if (live < CW'(2)) begin
          st_nxt = S_WRITE;
        end else begin
          raddr = is_back ? slot(head_r, t_r - CW'(ph_r ? 1 : 2))
                          : slot(head_r, t_r + CW'(ph_r ? 1 : 0));
          st_nxt = S_POP_MUL;
        end
      end
      S_POP_MUL: begin
        if (!ph_r) begin
          a1_nxt = $signed(rd_a); b1_nxt = $signed(rd_b);
          ph_nxt = 1'b1; st_nxt = S_POP_RD;
        end else begin
          ph_nxt = 1'b0; st_nxt = S_POP_LO;
        end
      end
      S_POP_LO: begin
        st_nxt = S_POP_HI;
      end
      S_POP_HI: begin
        st_nxt = S_POP_CMP;
      end
      S_POP_CMP: begin
        // middle line is needed when p1 < p2
        if (p1_r < p2_r) st_nxt = S_WRITE;
        else begin
          t_nxt = is_back ? t_r - 1'b1 : t_r + 1'b1;
          st_nxt = S_POP_RD;
        end
      end
      S_WRITE: begin
        if (live >= CW'(HULL_DEPTH)) begin
          res_nxt.status = ST_FULL;
        end else if (is_back) begin
          we = 1'b1; waddr = slot(head_r, t_r); cnt_nxt = t_r + 1'b1;
        end else begin
          // new head sits one before the first kept line
          we = 1'b1;
          waddr = slot(head_r, t_r);
          waddr = (waddr == '0) ? AW'(HULL_DEPTH - 1) : waddr - 1'b1;
          head_nxt = waddr; cnt_nxt = cnt_r - t_r + 1'b1;
        end
        st_nxt = S_DONE;
      end
      S_Q_RD: begin
        if (it_r.cmd == CMD_QRY_INC)
          raddr = slot(head_r, CW'(ph_r ? 1 : 0));
        else
          raddr = slot(head_r, cnt_r - CW'(ph_r ? 2 : 1));
        st_nxt = S_Q_MUL;
      end
      S_Q_MUL: begin
        if (cnt_r < CW'(2) || ph_r) st_nxt = S_Q_CMP;
        else begin ph_nxt = 1'b1; st_nxt = S_Q_RD; end
      end
      S_Q_CMP: begin
        // e0 = end line value, its neighbor's value in the low half of p1
        if (!ph_r) begin
          res_nxt.value = it_r.neg ? -e0_r : e0_r; st_nxt = S_DONE;
        end else if (it_r.cmd == CMD_QRY_INC ? (e0_r <= $signed(p1_r[63:0]))
                                              : ($signed(p1_r[63:0]) >= e0_r)) begin
          ph_nxt = 1'b0;
          if (it_r.cmd == CMD_QRY_INC) head_nxt = slot(head_r, CW'(1));
          cnt_nxt = cnt_r - 1'b1;
          st_nxt = S_Q_RD;
        end else begin
          res_nxt.value = it_r.neg ? -e0_r : e0_r; ph_nxt = 1'b0; st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        rv_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; head_r <= '0; cnt_r <= '0; rv_r <= 1'b0;
      linc_r <= 32'sh8000_0000; ldec_r <= 32'sh7fff_ffff; ph_r <= 1'b0;
    end else begin
      st_r <= st_nxt; head_r <= head_nxt; cnt_r <= cnt_nxt; rv_r <= rv_nxt;
      linc_r <= linc_nxt; ldec_r <= ldec_nxt; ph_r <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) it_r <= q_item;
    t_r <= t_nxt; res_r <= res_nxt; a1_r <= a1_nxt; b1_r <= b1_nxt;
    if (st_r == S_POP_MUL && ph_r) begin
      d1_r <= d1[33:0]; d2_r <= d2; d3_r <= d3[33:0]; d4_r <= d4;
    end
    if (st_r == S_POP_LO) begin
      p1_r <= 128'(lo1); p2_r <= 128'(lo2);
    end else if (st_r == S_POP_HI) begin
      p1_r <= p1_r + (128'(hi1) <<< 32);
      p2_r <= p2_r + (128'(hi2) <<< 32);
    end else if (st_r == S_Q_MUL && ph_r) begin
      p1_r <= 128'(ev[63:0]);
    end
    if (st_r == S_Q_MUL && !ph_r) e0_r <= ev[63:0];
  end

  assign res_valid = rv_r;
  assign res       = res_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(HULL_DEPTH)) else $error("line count beyond depth");
  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !q_ready) else $error("queue read while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE) |=> rv_r) else $error("result not raised");
endmodule

/* src/monotone_convex_hull_trick.sv */
// monotone_convex_hull_trick: top level, front queue plus hull sequencer
// depends on mcht_pkg, mcht_front, mcht_back, mcht_ram
//
//  channel | dir | contents
//  in_     | in  | tdata: cmd[1:0], slope[33:2], intercept[95:34], query_x[127:96]
//  out_    | out | tdata: best_value[63:0]; tuser: status[1:0]
//  cfg_    | in  | minimize_mode, written when cfg_wr_en is high
//
// an add on an empty hull goes straight to the write, else it checks the end slope
// and runs cross-product tests (two memory reads, then each 34 x 64 product in two
// halves); a query reads the end line and any neighbor, popping the end line while
// the neighbor is as good; order flags end early; the single read port sets the pace
// reset clears counts, head and the last-x marks; line memories are not cleared
// a stalled result holds the sequencer while the front queue keeps taking two items
module monotone_convex_hull_trick #(
  parameter int HULL_DEPTH = mcht_pkg::DEF_HULL_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // cmd, slope, intercept, query_x
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // best_value
  output logic [1:0]   out_tuser,  // status
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data
);
  import mcht_pkg::*;

  logic    minimize_r;
  logic    q_valid, q_ready;
  item_t   q_item;
  result_t res;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minimize_r <= 1'b0;
    end else if (cfg_wr_en) begin
      minimize_r <= cfg_wr_data;
    end
  end

  mcht_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_cmd(in_tdata[1:0]), .in_slope(in_tdata[33:2]),
    .in_intercept(in_tdata[95:34]), .in_query_x(in_tdata[127:96]),
    .minimize(minimize_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item));

  mcht_back #(.HULL_DEPTH(HULL_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res));

  assign out_tdata = res.value;
  assign out_tuser = res.status;
endmodule

/* test/mcht_checker.sv */
// mcht_checker: watches the hull block's channels, predicts each result and compares
// depends on mcht_pkg for the default depth and the command and status codes
`timescale 1ns / 100ps

module mcht_checker #(
  parameter int HULL_DEPTH = mcht_pkg::DEF_HULL_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  output int           fail_count,
  output int           pending,
  output int           n_checked,
  output int           n_values,
  output int           n_flagged
);
  import mcht_pkg::*;

  typedef struct {
    longint  value;
    status_t status;
  } hull_result_t;

  hull_result_t expected_q[$];

  // stored lines, negated when taken in minimize mode
  longint slope_mem[HULL_DEPTH];
  longint icpt_mem[HULL_DEPTH];
  int     head;
  int     count;
  longint last_inc_x;
  longint last_dec_x;
  bit     minimize;

  function automatic int slot(int p);
    return (head + p) % HULL_DEPTH;
  endfunction

  function automatic longint line_at(int p, longint x);
    return slope_mem[slot(p)] * x + icpt_mem[slot(p)];
  endfunction

  // exact cross product: is (a2,b2) still on the envelope between its neighbors
  function automatic bit keeps_middle(longint a1, longint b1, longint a2, longint b2,
                                      longint a3, longint b3);
    logic signed [127:0] lhs;
    logic signed [127:0] rhs;
    lhs = (a3 - a1) * (b1 - b2);
    rhs = (a2 - a1) * (b1 - b3);
    return lhs < rhs;
  endfunction

  function automatic status_t append_back(longint a, longint b);
    int t;
    t = count;
    if (t > 0 && slope_mem[slot(t - 1)] > a) return ST_ORDER;
    while (t >= 2) begin
      if (keeps_middle(slope_mem[slot(t - 2)], icpt_mem[slot(t - 2)],
                       slope_mem[slot(t - 1)], icpt_mem[slot(t - 1)], a, b)) break;
      t--;
    end
    if (t >= HULL_DEPTH) return ST_FULL;
    slope_mem[slot(t)] = a;
    icpt_mem[slot(t)] = b;
    count = t + 1;
    return ST_OK;
  endfunction

  function automatic status_t prepend_front(longint a, longint b);
    int drop;
    drop = 0;
    if (count > 0 && a > slope_mem[slot(0)]) return ST_ORDER;
    while (count - drop >= 2) begin
      if (keeps_middle(a, b, slope_mem[slot(drop)], icpt_mem[slot(drop)],
                       slope_mem[slot(drop + 1)], icpt_mem[slot(drop + 1)])) break;
      drop++;
    end
    if (count - drop >= HULL_DEPTH) return ST_FULL;
    head = (head + drop + HULL_DEPTH - 1) % HULL_DEPTH;
    count = count - drop + 1;
    slope_mem[head] = a;
    icpt_mem[head] = b;
    return ST_OK;
  endfunction

  function automatic hull_result_t apply_item(cmd_t c, longint a, longint b, longint x);
    hull_result_t r;
    r.value = 0;
    r.status = ST_OK;
    case (c)
      CMD_ADD_BACK: r.status = minimize ? prepend_front(-a, -b) : append_back(a, b);
      CMD_ADD_FRONT: r.status = minimize ? append_back(-a, -b) : prepend_front(a, b);
      CMD_QRY_INC: begin
        if (x < last_inc_x) r.status = ST_ORDER;
        else if (count == 0) r.status = ST_EMPTY;
        else begin
          last_inc_x = x;
          while (count >= 2 && line_at(0, x) <= line_at(1, x)) begin
            head = (head + 1) % HULL_DEPTH;
            count--;
          end
          r.value = line_at(0, x);
        end
      end
      default: begin
        if (x > last_dec_x) r.status = ST_ORDER;
        else if (count == 0) r.status = ST_EMPTY;
        else begin
          last_dec_x = x;
          while (count >= 2 && line_at(count - 2, x) >= line_at(count - 1, x)) count--;
          r.value = line_at(count - 1, x);
        end
      end
    endcase
    if (r.status == ST_OK && (c == CMD_QRY_INC || c == CMD_QRY_DEC) && minimize)
      r.value = -r.value;
    return r;
  endfunction

  always @(posedge clk) begin
    hull_result_t e;
    hull_result_t p;
    longint a;
    longint b;
    longint x;
    if (!rst_n) begin
      expected_q.delete();
      head = 0;
      count = 0;
      last_inc_x = -64'sd2147483648;
      last_dec_x = 64'sd2147483647;
      minimize = 1'b0;
      fail_count = 0;
      n_checked = 0;
      n_values = 0;
      n_flagged = 0;
    end else begin
      // results first, so an item taken at the same edge cannot match itself
      if (out_tvalid && out_tready) begin
        n_checked++;
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected: best_value %0d status %0d",
                 $signed(out_tdata), out_tuser);
          fail_count++;
        end else begin
          e = expected_q[0];
          expected_q.delete(0);
          if (e.status == ST_OK && out_tuser == ST_OK) n_values++;
          if (e.status != ST_OK) n_flagged++;
          if (out_tdata !== e.value) begin
            $error("best_value: expected %0d, actual %0d", e.value, $signed(out_tdata));
            fail_count++;
          end
          if (out_tuser !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, out_tuser);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        a = $signed(in_tdata[33:2]);
        b = $signed(in_tdata[95:34]);
        x = $signed(in_tdata[127:96]);
        p = apply_item(cmd_t'(in_tdata[1:0]), a, b, x);
        expected_q.push_back(p);
      end
      if (cfg_wr_en) minimize = cfg_wr_data;
    end
    pending = expected_q.size();
  end

endmodule

/* test/monotone_convex_hull_trick_test.sv */
// monotone_convex_hull_trick_test: stimulus and verdict for the hull block
// depends on mcht_pkg, mcht_checker and the block itself
`timescale 1ns / 100ps

module monotone_convex_hull_trick_test;
  import mcht_pkg::*;

  localparam int     CYCLE_LIMIT = 1_000_000;
  localparam int     BLOCK_ITEMS = 170;
  localparam longint X_MIN = -64'sd2147483648;
  localparam longint X_MAX = 64'sd2147483647;
  localparam longint B_MIN = -64'sd2305843009213693952;
  localparam longint B_MAX = 64'sd2305843009213693951;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;    // cmd, slope, intercept, query_x
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;        // best_value
  logic [1:0]   out_tuser;        // status
  logic         cfg_wr_en = 1'b0;
  logic         cfg_wr_data = 1'b0;

  int fail_count;
  int pending;
  int n_checked;
  int n_values;
  int n_flagged;
  int cycles = 0;
  int items_sent = 0;

  bit quiet = 1'b0;          // no idling on either side
  bit long_stall_go = 1'b0;  // ask the receiver for one long hold-off

  // stimulus bookkeeping, slopes in stored form so the mode does not matter
  bit     mode = 1'b0;
  longint hi_slope = 0;
  longint lo_slope = 0;
  longint inc_x = 0;
  longint dec_x = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  monotone_convex_hull_trick dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  mcht_checker hull_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .pending    (pending),
    .n_checked  (n_checked),
    .n_values   (n_values),
    .n_flagged  (n_flagged)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random ready bursts, one long hold-off on request
  initial begin
    bit stall_done;
    stall_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_go && !stall_done) begin
        out_tready = 1'b0;
        repeat (150) @(negedge clk);
        stall_done = 1'b1;
      end else if (quiet) begin
        out_tready = 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end
    end
  end

  // one input transfer; called and returns at a falling edge
  task automatic send_item(cmd_t c, longint a, longint b, longint x);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {x[31:0], b[61:0], a[31:0], c};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // add a line given in stored form at the back or the front of the hull
  task automatic add_stored(bit at_back, longint s, longint bst, bit track);
    cmd_t c;
    if (mode) c = at_back ? CMD_ADD_FRONT : CMD_ADD_BACK;
    else c = at_back ? CMD_ADD_BACK : CMD_ADD_FRONT;
    send_item(c, mode ? -s : s, mode ? -bst : bst, longint'(int'($urandom)));
    if (track && s > hi_slope) hi_slope = s;
    if (track && s < lo_slope) lo_slope = s;
  endtask

  task automatic query(cmd_t c, longint x);
    send_item(c, longint'(int'($urandom)), longint'(int'($urandom)), x);
  endtask

  // register write once nothing is left in flight
  task automatic set_mode(bit m);
    in_tvalid = 1'b0;
    wait (pending == 0);
    @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = m;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    mode = m;
  endtask

  // lines with slopes rising by one and intercept -16*k*k all stay on the envelope: runs into full
  task automatic fill_hull();
    for (int k = 1; k <= 70; k++) begin
      add_stored(1'b1, hi_slope + 1, -longint'(k * k) * 16, 1'b1);
    end
  endtask

  task automatic random_item();
    int     r;
    longint s;
    longint b;
    longint x;
    longint raw;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) begin
      raw = {$urandom, $urandom};
      b = (raw <<< 2) >>> 2;
    end else begin
      b = longint'($urandom_range(0, 200000)) - 100000;
    end
    if (r < 25) begin
      s = hi_slope + $urandom_range(0, 8);
      if (s > X_MAX) s = X_MAX;
      add_stored(1'b1, s, b, 1'b1);
    end else if (r < 50) begin
      s = lo_slope - $urandom_range(0, 8);
      if (s < -X_MAX) s = -X_MAX;
      add_stored(1'b0, s, b, 1'b1);
    end else if (r < 68) begin
      inc_x = inc_x + $urandom_range(0, 3000);
      if (inc_x > X_MAX) inc_x = X_MAX;
      query(CMD_QRY_INC, inc_x);
    end else if (r < 86) begin
      dec_x = dec_x - $urandom_range(0, 3000);
      if (dec_x < X_MIN) dec_x = X_MIN;
      query(CMD_QRY_DEC, dec_x);
    end else if (r < 93) begin
      // random slope added on the wrong end of the held range: order violation
      s = longint'(int'($urandom));
      if (mode) s = -s;
      if (s < lo_slope) add_stored(1'b1, s, b, 1'b0);
      else if (s > hi_slope) add_stored(1'b0, s, b, 1'b0);
      else add_stored($urandom_range(0, 1), s, b, 1'b0);
    end else if ($urandom_range(0, 1) == 0 && inc_x > X_MIN) begin
      x = inc_x - 1 - (longint'($urandom) % (inc_x - X_MIN));
      query(CMD_QRY_INC, x);
    end else if (dec_x < X_MAX) begin
      x = dec_x + 1 + (longint'($urandom) % (X_MAX - dec_x));
      query(CMD_QRY_DEC, x);
    end else begin
      query(CMD_QRY_INC, inc_x);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty hull, order violations, equal slopes, both ends
    query(CMD_QRY_INC, X_MIN);
    query(CMD_QRY_DEC, X_MAX);
    add_stored(1'b1, 0, 0, 1'b1);
    add_stored(1'b1, -1, 5, 1'b0);
    add_stored(1'b0, 0, 10, 1'b1);
    add_stored(1'b0, 1, 0, 1'b0);
    add_stored(1'b1, 2, -4, 1'b1);
    add_stored(1'b0, -2, -4, 1'b1);
    add_stored(1'b1, 4, -16, 1'b1);
    query(CMD_QRY_INC, 0);
    query(CMD_QRY_INC, -1);
    query(CMD_QRY_DEC, 0);
    query(CMD_QRY_DEC, 1);
    add_stored(1'b1, 4, -16, 1'b1);
    query(CMD_QRY_INC, 1);
    inc_x = 1;
    set_mode(1'b1);
    add_stored(1'b1, 6, -30, 1'b1);
    add_stored(1'b0, -5, -40, 1'b1);
    query(CMD_QRY_INC, 3);
    query(CMD_QRY_DEC, -3);
    inc_x = 3;
    dec_x = -3;

    // random blocks alternating the mode; the last one ends without idling
    for (int blk = 0; blk < 5; blk++) begin
      set_mode(blk % 2 == 1);
      if (blk < 2) fill_hull();
      if (blk == 2) long_stall_go = 1'b1;
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        if (blk == 4 && i == 50) quiet = 1'b1;
        random_item();
      end
    end

    // closing extremes: widest slopes and intercepts, x at both limits
    set_mode(1'b0);
    add_stored(1'b1, X_MAX, B_MAX, 1'b1);
    add_stored(1'b0, X_MIN, B_MIN, 1'b1);
    query(CMD_QRY_INC, X_MAX);
    query(CMD_QRY_DEC, X_MIN);
    in_tvalid = 1'b0;

    wait (pending == 0);
    repeat (300) @(posedge clk);
    $display("sent %0d items over both modes; %0d results checked", items_sent, n_checked);
    $display("%0d results with status ok, %0d flagged items", n_values, n_flagged);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
